// ===== rtl/core/matrix3_inverse_core_defines.svh =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core assertion macros
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MATRIX3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3_INVERSE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define M3I_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define M3I_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define M3I_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define M3I_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/m3inv_pkg.sv =====
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types and constants of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int LANES        = 9;  // one lane per inverse element
	localparam int FRONT_STAGES = 6;  // cofactor / determinant pipeline depth

	typedef struct packed {
		logic zero;  // determinant exactly zero
		logic clip;  // determinant output clipped
	} det_flags_t;

endpackage

// ===== rtl/core/m3inv_front.sv =====
// ----------------------------------------------------------------------------
// m3inv_front
// Cofactors, exact determinant, and per-lane operand prep for the dividers.
// ----------------------------------------------------------------------------
module m3inv_front
	import m3inv_pkg::*;
#(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int DW = 3*W+2,
	parameter int NW = 2*W+1+2*F
) (
	input  logic                clk,
	input  logic                adv,
	input  logic signed [W-1:0] m [LANES],
	output logic [NW-1:0]       num_mag [LANES],
	output logic                q_neg [LANES],
	output logic [DW-1:0]       den_mag,
	output logic signed [W-1:0] det_val,
	output det_flags_t          det_flags
);

	localparam logic [DW-1:0] RND  = (DW'(1) << (2*F)) - DW'(1);
	localparam logic [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] pa_s1 [LANES];
	logic signed [2*W-1:0] pb_s1 [LANES];
	logic signed [2*W:0]   cof_s2 [LANES];
	logic signed [2*W:0]   cof_s3 [LANES];
	logic signed [2*W:0]   cof_s4 [LANES];
	logic signed [2*W:0]   cof_s5 [LANES];
	logic signed [W-1:0]   col_s1 [3];
	logic signed [W-1:0]   col_s2 [3];
	logic signed [2*W:0]   pl_s3 [3];
	logic signed [2*W:0]   ph_s3 [3];
	logic signed [DW-1:0]  prod_s4 [3];
	logic signed [DW-1:0]  det_s5;

	logic [NW-1:0]         num_s6 [LANES];
	logic                  neg_s6 [LANES];
	logic [DW-1:0]         den_s6;
	logic signed [W-1:0]   detv_s6;
	det_flags_t            flags_s6;

	logic signed [DW-1:0]  det_rnd;
	logic signed [DW-1:0]  det_sh;
	logic                  det_fit;

	// cof[3k+t] = component t of cross(column k+1, column k+2)
	for (genvar c = 0; c < LANES; c++) begin : g_cof
		localparam int K  = c / 3;
		localparam int T  = c % 3;
		localparam int CI = (K + 1) % 3;
		localparam int CJ = (K + 2) % 3;
		localparam int U  = (T + 1) % 3;
		localparam int V  = (T + 2) % 3;
		logic [2*W:0] mag;

		assign mag = cof_s5[c][2*W] ? (2*W+1)'(-cof_s5[c]) : cof_s5[c];

		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s1[c]  <= m[U + 3*CI] * m[V + 3*CJ];
				pb_s1[c]  <= m[V + 3*CI] * m[U + 3*CJ];
				cof_s2[c] <= (2*W+1)'(pa_s1[c]) - (2*W+1)'(pb_s1[c]);
				cof_s3[c] <= cof_s2[c];
				cof_s4[c] <= cof_s3[c];
				cof_s5[c] <= cof_s4[c];
				num_s6[c] <= {mag, {(2*F){1'b0}}};
				neg_s6[c] <= cof_s5[c][2*W] ^ det_s5[DW-1];
			end
		end

		assign num_mag[c] = num_s6[c];
		assign q_neg[c]   = neg_s6[c];
	end

	// det = sum over rows of m[t][0] * cof[t], wide product split at W
	for (genvar t = 0; t < 3; t++) begin : g_det
		always_ff @(posedge clk) begin
			if (adv) begin
				col_s1[t]  <= m[t];
				col_s2[t]  <= col_s1[t];
				pl_s3[t]   <= col_s2[t] * $signed({1'b0, cof_s2[t][W-1:0]});
				ph_s3[t]   <= col_s2[t] * $signed(cof_s2[t][2*W:W]);
				prod_s4[t] <= (DW'(ph_s3[t]) <<< W) + DW'(pl_s3[t]);
			end
		end
	end

	// truncate toward zero: bias negatives before the arithmetic shift
	assign det_rnd = det_s5 + $signed(det_s5[DW-1] ? RND : '0);
	assign det_sh  = det_rnd >>> (2*F);
	assign det_fit = (det_sh[DW-1:W-1] == '0) || (det_sh[DW-1:W-1] == '1);

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s5         <= prod_s4[0] + prod_s4[1] + prod_s4[2];
			den_s6         <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			detv_s6        <= det_fit ? det_sh[W-1:0] : (det_s5[DW-1] ? SMIN : SMAX);
			flags_s6.zero  <= (det_s5 == '0);
			flags_s6.clip  <= !det_fit;
		end
	end

	assign den_mag   = den_s6;
	assign det_val   = detv_s6;
	assign det_flags = flags_s6;

endmodule

// ===== rtl/core/m3inv_lane.sv =====
// ----------------------------------------------------------------------------
// m3inv_lane
// Pipelined restoring divider, one quotient bit per stage, then saturation.
// ----------------------------------------------------------------------------
module m3inv_lane #(
	parameter int W  = 32,
	parameter int DW = 3*W+2,
	parameter int NW = 2*W+33
) (
	input  logic                clk,
	input  logic                adv,
	input  logic [NW-1:0]       num_mag,
	input  logic                q_neg,
	input  logic [DW-1:0]       den_mag,
	output logic signed [W-1:0] res,
	output logic                clip
);

	localparam int RW = DW + W;
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic [RW-1:0] rem_s [W+1];
	logic [W-1:0]  quo_s [W+1];
	logic [DW-1:0] den_s [W+1];
	logic          neg_s [W+1];
	logic          ovf_s [W+1];

	logic [W-1:0]        q;
	logic                big;
	logic                rest;
	logic                clip_c;
	logic signed [W-1:0] res_c;
	logic signed [W-1:0] res_q;
	logic                clip_q;

	// quotient of W magnitude bits; anything larger is flagged up front
	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= RW'(num_mag);
			ovf_s[0] <= RW'(num_mag) >= (RW'(den_mag) << W);
			quo_s[0] <= '0;
			neg_s[0] <= q_neg;
			den_s[0] <= den_mag;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_bit
		localparam int B = W - j;
		logic [RW-1:0] trial;
		logic          fit;

		assign trial = RW'(den_s[j-1]) << B;
		assign fit   = rem_s[j-1] >= trial;

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j] <= fit ? rem_s[j-1] - trial : rem_s[j-1];
				quo_s[j] <= quo_s[j-1] | ({{(W-1){1'b0}}, fit} << B);
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				den_s[j] <= den_s[j-1];
			end
		end
	end

	assign q    = quo_s[W];
	assign big  = q[W-1];
	assign rest = (q[W-2:0] != '0);

	always_comb begin
		clip_c = ovf_s[W] || (neg_s[W] ? (big && rest) : big);
		if (clip_c) begin
			res_c = neg_s[W] ? SMIN : SMAX;
		end else begin
			res_c = neg_s[W] ? (~q + 1'b1) : q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q  <= res_c;
			clip_q <= clip_c;
		end
	end

	assign res  = res_q;
	assign clip = clip_q;

endmodule

// ===== rtl/core/m3inv_merge.sv =====
// ----------------------------------------------------------------------------
// m3inv_merge
// Aligns determinant info with the lanes, merges flags, output reg + skid.
// ----------------------------------------------------------------------------
`include "matrix3_inverse_core_defines.svh"

module m3inv_merge
	import m3inv_pkg::*;
#(
	parameter int W     = 32,
	parameter int DEPTH = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                last_valid,
	input  logic signed [W-1:0] res [LANES],
	input  logic                clip [LANES],
	input  logic signed [W-1:0] det_val,
	input  det_flags_t          det_flags,
	output logic                hold,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [W-1:0] b [LANES],
	output logic signed [W-1:0] det_value,
	output logic                singular,
	output logic                saturated
);

	logic signed [W-1:0] det_d [DEPTH];
	det_flags_t          flg_d [DEPTH];

	logic signed [W-1:0] c_b [LANES];
	logic signed [W-1:0] c_det;
	logic                c_sing;
	logic                c_sat;
	logic                any_clip;

	logic signed [W-1:0] sk_b_q [LANES];
	logic signed [W-1:0] sk_det_q;
	logic                sk_sing_q;
	logic                sk_sat_q;
	logic                sk_v_q;

	logic signed [W-1:0] o_b_q [LANES];
	logic signed [W-1:0] o_det_q;
	logic                o_sing_q;
	logic                o_sat_q;
	logic                ov_q;

	logic                incoming;
	logic                free;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_d[0] <= det_val;
			flg_d[0] <= det_flags;
		end
	end

	for (genvar i = 1; i < DEPTH; i++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				det_d[i] <= det_d[i-1];
				flg_d[i] <= flg_d[i-1];
			end
		end
	end

	// singular: zero everything, no clip reported
	always_comb begin
		any_clip = flg_d[DEPTH-1].clip;
		for (int k = 0; k < LANES; k++) begin
			any_clip = any_clip | clip[k];
			c_b[k]   = flg_d[DEPTH-1].zero ? '0 : res[k];
		end
		c_det  = flg_d[DEPTH-1].zero ? '0 : det_d[DEPTH-1];
		c_sing = flg_d[DEPTH-1].zero;
		c_sat  = !flg_d[DEPTH-1].zero && any_clip;
	end

	assign incoming = last_valid && !sk_v_q;
	assign free     = !ov_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (free) begin
			ov_q   <= sk_v_q || incoming;
			sk_v_q <= 1'b0;
		end else if (incoming) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			for (int k = 0; k < LANES; k++) begin
				o_b_q[k] <= sk_v_q ? sk_b_q[k] : c_b[k];
			end
			o_det_q  <= sk_v_q ? sk_det_q : c_det;
			o_sing_q <= sk_v_q ? sk_sing_q : c_sing;
			o_sat_q  <= sk_v_q ? sk_sat_q : c_sat;
		end else if (incoming) begin
			sk_b_q    <= c_b;
			sk_det_q  <= c_det;
			sk_sing_q <= c_sing;
			sk_sat_q  <= c_sat;
		end
	end

	assign hold      = sk_v_q;
	assign out_valid = ov_q;
	assign b         = o_b_q;
	assign det_value = o_det_q;
	assign singular  = o_sing_q;
	assign saturated = o_sat_q;

	`M3I_ASSERT_IMP(a_sing_zero, clk, arst_n, ov_q && o_sing_q, !o_sat_q && o_det_q == '0 && o_b_q[0] == '0, "singular result not zeroed")
	`M3I_ASSERT_IMP(a_skid_behind_out, clk, arst_n, sk_v_q, ov_q, "skid holds data with empty output register")

endmodule

// ===== rtl/core/matrix3_inverse_core.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// 3x3 matrix inverse by adjugate, signed fixed point, nine divider lanes.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       input      in_valid / in_stall    a_r0c0 .. a_r2c2
// out      output     out_valid / out_stall  b_r0c0 .. b_r2c2, det_value,
//                                            singular, saturated
//
// One matrix accepted per cycle while in_stall is low. Depth is set by the
// divider lanes: one quotient bit per stage, WORD_BITS stages plus an overflow
// check and a saturation stage, after six stages of cofactor and determinant
// products. Reset clears only the valid bits.
// An output register with a one-entry skid absorbs out_stall; in_stall is
// the registered skid-full flag, and the whole pipeline holds while it is set.
// ----------------------------------------------------------------------------
`include "matrix3_inverse_core_defines.svh"

module matrix3_inverse_core
	import m3inv_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [WORD_BITS-1:0] a_r0c0,
	input  logic signed [WORD_BITS-1:0] a_r1c0,
	input  logic signed [WORD_BITS-1:0] a_r2c0,
	input  logic signed [WORD_BITS-1:0] a_r0c1,
	input  logic signed [WORD_BITS-1:0] a_r1c1,
	input  logic signed [WORD_BITS-1:0] a_r2c1,
	input  logic signed [WORD_BITS-1:0] a_r0c2,
	input  logic signed [WORD_BITS-1:0] a_r1c2,
	input  logic signed [WORD_BITS-1:0] a_r2c2,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [WORD_BITS-1:0] b_r0c0,
	output logic signed [WORD_BITS-1:0] b_r0c1,
	output logic signed [WORD_BITS-1:0] b_r0c2,
	output logic signed [WORD_BITS-1:0] b_r1c0,
	output logic signed [WORD_BITS-1:0] b_r1c1,
	output logic signed [WORD_BITS-1:0] b_r1c2,
	output logic signed [WORD_BITS-1:0] b_r2c0,
	output logic signed [WORD_BITS-1:0] b_r2c1,
	output logic signed [WORD_BITS-1:0] b_r2c2,
	output logic signed [WORD_BITS-1:0] det_value,
	output logic                        singular,
	output logic                        saturated
);

	localparam int W      = WORD_BITS;
	localparam int DW     = 3*W + 2;
	localparam int NW     = 2*W + 1 + 2*FRAC_BITS;
	localparam int LSTG   = W + 2;
	localparam int NP     = FRONT_STAGES + LSTG;

	logic                adv;
	logic                hold;
	logic [NP-1:0]       v_q;

	logic signed [W-1:0] m [LANES];
	logic [NW-1:0]       num_mag [LANES];
	logic                q_neg [LANES];
	logic [DW-1:0]       den_mag;
	logic signed [W-1:0] det_val;
	det_flags_t          det_flags;
	logic signed [W-1:0] res [LANES];
	logic                clip [LANES];
	logic signed [W-1:0] b [LANES];

	assign m[0] = a_r0c0;
	assign m[1] = a_r1c0;
	assign m[2] = a_r2c0;
	assign m[3] = a_r0c1;
	assign m[4] = a_r1c1;
	assign m[5] = a_r2c1;
	assign m[6] = a_r0c2;
	assign m[7] = a_r1c2;
	assign m[8] = a_r2c2;

	assign adv      = !hold;
	assign in_stall = hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NP-2:0], in_valid};
		end
	end

	m3inv_front #(
		.W  (W),
		.F  (FRAC_BITS),
		.DW (DW),
		.NW (NW)
	) u_front (
		.clk       (clk),
		.adv       (adv),
		.m         (m),
		.num_mag   (num_mag),
		.q_neg     (q_neg),
		.den_mag   (den_mag),
		.det_val   (det_val),
		.det_flags (det_flags)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		m3inv_lane #(
			.W  (W),
			.DW (DW),
			.NW (NW)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.num_mag (num_mag[k]),
			.q_neg   (q_neg[k]),
			.den_mag (den_mag),
			.res     (res[k]),
			.clip    (clip[k])
		);
	end

	m3inv_merge #(
		.W     (W),
		.DEPTH (LSTG)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.last_valid (v_q[NP-1]),
		.res        (res),
		.clip       (clip),
		.det_val    (det_val),
		.det_flags  (det_flags),
		.hold       (hold),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.b          (b),
		.det_value  (det_value),
		.singular   (singular),
		.saturated  (saturated)
	);

	assign b_r0c0 = b[0];
	assign b_r0c1 = b[1];
	assign b_r0c2 = b[2];
	assign b_r1c0 = b[3];
	assign b_r1c1 = b[4];
	assign b_r1c2 = b[5];
	assign b_r2c0 = b[6];
	assign b_r2c1 = b[7];
	assign b_r2c2 = b[8];

	`M3I_ASSERT_NXT(a_hold_freezes, clk, arst_n, in_stall, $stable(v_q), "pipeline moved while holding")

endmodule

// ===== tb/matrix3_inverse_core_tb.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_core_tb
// Self-checking bench for the 3x3 fixed-point matrix inverse core: directed
// matrices (identity, zero, extremes, singular, clipping) followed by random
// matrices, with bursty input traffic, random output stalls and one long
// output hold-off. Each result is checked against a hand-typed answer or a
// wide-integer adjugate model in the bench.
// ----------------------------------------------------------------------------
module matrix3_inverse_core_tb;
	import m3inv_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WB = 32;
	localparam int FB = 16;
	localparam int N_RANDOM = 1100;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;

	typedef logic signed [191:0] wide_t;
	typedef logic [WB-1:0] word_t;

	typedef struct {
		word_t inv[9];
		word_t det;
		logic  sing;
		logic  sat;
	} inverse_t;

	typedef struct {
		word_t    mat[9];  // column major: row + 3*col
		bit       typed;
		inverse_t ans;
	} matrix_row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	word_t a[9];
	word_t b[9];
	word_t det_value;
	logic singular, saturated;

	inverse_t pending_q[$];
	int errors = 0, n_out = 0, n_sing = 0, n_sat = 0, cycles = 0;
	bit hold_req = 0, hold_done = 0;

	matrix3_inverse_core #(.WORD_BITS(WB), .FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_r0c0(a[0]), .a_r1c0(a[1]), .a_r2c0(a[2]),
		.a_r0c1(a[3]), .a_r1c1(a[4]), .a_r2c1(a[5]),
		.a_r0c2(a[6]), .a_r1c2(a[7]), .a_r2c2(a[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.b_r0c0(b[0]), .b_r0c1(b[1]), .b_r0c2(b[2]),
		.b_r1c0(b[3]), .b_r1c1(b[4]), .b_r1c2(b[5]),
		.b_r2c0(b[6]), .b_r2c1(b[7]), .b_r2c2(b[8]),
		.det_value(det_value), .singular(singular), .saturated(saturated)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic word_t clip_word(input wide_t x, inout logic c);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (WB - 1)) - 1;
		lo = -(wide_t'(1) <<< (WB - 1));
		if (x > hi) begin
			c = 1;
			return word_t'(hi);
		end
		if (x < lo) begin
			c = 1;
			return word_t'(lo);
		end
		return x[WB-1:0];
	endfunction

	function automatic inverse_t adjugate_inverse(input word_t mat[9]);
		wide_t m[9], cof[9], d, scale;
		inverse_t r;
		logic c;
		int ci, cj, u, v;
		c = 0;
		for (int i = 0; i < 9; i++) m[i] = {{(192-WB){mat[i][WB-1]}}, mat[i]};
		for (int k = 0; k < 3; k++) begin
			ci = (k + 1) % 3;
			cj = (k + 2) % 3;
			for (int t = 0; t < 3; t++) begin
				u = (t + 1) % 3;
				v = (t + 2) % 3;
				cof[3*k+t] = m[u+3*ci] * m[v+3*cj] - m[v+3*ci] * m[u+3*cj];
			end
		end
		d = m[0] * cof[0] + m[1] * cof[1] + m[2] * cof[2];
		scale = wide_t'(1) <<< (2 * FB);
		r.sing = (d == 0);
		if (r.sing) begin
			foreach (r.inv[i]) r.inv[i] = '0;
			r.det = '0;
			r.sat = 0;
			return r;
		end
		for (int i = 0; i < 9; i++) r.inv[i] = clip_word((cof[i] * scale) / d, c);
		r.det = clip_word(d / scale, c);
		r.sat = c;
		return r;
	endfunction

	// sender: one transfer per call, input stall sampled mid-cycle
	task automatic send_matrix(input word_t mat[9], input inverse_t ans);
		logic st;
		in_valid <= 1;
		for (int i = 0; i < 9; i++) a[i] <= mat[i];
		do begin
			@(negedge clk) st = in_stall;
			@(posedge clk);
		end while (st);
		pending_q.push_back(ans);
	endtask

	task automatic maybe_gap();
		int g;
		if ($urandom_range(0, 5) == 0) begin
			g = $urandom_range(1, 6);
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic word_t rand_elem(input int mode);
		case (mode)
			0: return $urandom();
			1: return word_t'($signed($urandom_range(0, 2**19)) - 2**18);
			default: return word_t'($signed($urandom_range(0, 2**21)) - 2**20);
		endcase
	endfunction

	// receiver: random stall pattern, plus one long hold-off on request
	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
				out_stall <= 0;
			end else if ($urandom_range(0, 99) < 30)
				out_stall <= ($urandom_range(0, 1) == 1);
		end
	end

	always @(negedge clk) begin
		inverse_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: result transfer with nothing expected", $realtime);
			end else begin
				e = pending_q.pop_front();
				n_out++;
				if (singular) n_sing++;
				if (saturated) n_sat++;
				for (int i = 0; i < 9; i++)
					if (b[i] !== e.inv[i]) begin
						errors++;
						$display("%0t: inv[%0d] exp %h got %h", $realtime, i, e.inv[i], b[i]);
					end
				if (det_value !== e.det) begin
					errors++;
					$display("%0t: det exp %h got %h", $realtime, e.det, det_value);
				end
				if (singular !== e.sing || saturated !== e.sat) begin
					errors++;
					$display("%0t: flags exp sing %b sat %b got %b %b", $realtime,
						e.sing, e.sat, singular, saturated);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		matrix_row_t dir[$];
		matrix_row_t row;
		word_t mat[9];
		word_t one, mx, mn;
		int mode, wait_n, src;
		one = 32'h0001_0000;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		in_valid = 0;
		foreach (a[i]) a[i] = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// identity
		row = '{default: '0};
		row.mat[0] = one; row.mat[4] = one; row.mat[8] = one;
		row.typed = 1;
		row.ans.inv[0] = one; row.ans.inv[4] = one; row.ans.inv[8] = one;
		row.ans.det = one;
		dir.push_back(row);
		// zero matrix: singular
		row = '{default: '0};
		row.typed = 1; row.ans.sing = 1;
		dir.push_back(row);
		// all max / all min: rank one, singular
		foreach (row.mat[i]) row.mat[i] = mx;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = mn;
		dir.push_back(row);
		// smallest diagonal: inverse clips high, det truncates to zero
		row = '{default: '0};
		row.mat[0] = 1; row.mat[4] = 1; row.mat[8] = 1;
		row.typed = 1; row.ans.sat = 1;
		row.ans.inv[0] = mx; row.ans.inv[4] = mx; row.ans.inv[8] = mx;
		dir.push_back(row);
		// most negative diagonal: det clips low, inverse is -2 lsb
		row = '{default: '0};
		row.mat[0] = mn; row.mat[4] = mn; row.mat[8] = mn;
		row.typed = 1; row.ans.sat = 1; row.ans.det = mn;
		row.ans.inv[0] = -2; row.ans.inv[4] = -2; row.ans.inv[8] = -2;
		dir.push_back(row);
		// predictor-checked extremes and mixes
		row = '{default: '0};
		foreach (row.mat[i]) row.mat[i] = (i % 2) ? mx : mn;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = (i % 4 == 0) ? mx : '0;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = (i % 4 == 0) ? mn : 32'hffff_ffff;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = (i % 4 == 0) ? 32'h0002_0000 : 32'h0000_8000;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = word_t'(i * 32'h1_0000 + 32'h1_0000);
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = (i == 2 || i == 4 || i == 6) ? one : '0;
		dir.push_back(row);
		foreach (row.mat[i]) row.mat[i] = (i % 4 == 0) ? 32'hfff0_0000 : 32'h0000_0001;
		dir.push_back(row);

		foreach (dir[r]) begin
			if (!dir[r].typed) dir[r].ans = adjugate_inverse(dir[r].mat);
			send_matrix(dir[r].mat, dir[r].ans);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) hold_req = 1;
			mode = $urandom_range(0, 4);
			foreach (mat[i]) mat[i] = rand_elem(mode == 0 ? 0 : (mode < 3 ? 1 : 2));
			// some singular ones: column 2 repeats column 0 or column 1
			if ($urandom_range(0, 9) == 0) begin
				src = $urandom_range(0, 1);
				for (int r = 0; r < 3; r++) mat[r + 6] = mat[r + 3 * src];
			end
			send_matrix(mat, adjugate_inverse(mat));
			maybe_gap();
		end
		in_valid <= 0;

		wait_n = 0;
		while (pending_q.size() != 0 && wait_n < 20000) begin
			@(posedge clk);
			wait_n++;
		end
		repeat (100) @(posedge clk);
		if (pending_q.size() != 0) begin
			errors++;
			$display("%0t: results missing, exp 0 pending got %0d", $realtime,
				pending_q.size());
		end
		$display("%0d inverses checked, %0d singular, %0d clipped; long output hold-off %s",
			n_out, n_sing, n_sat, hold_done ? "done" : "skipped");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
